### rtl/qmm_pkg.sv
package qmm_pkg;

	localparam int ROTORS = 4;

	// Divider pipeline shared by the rescale and yaw-limit quotients.
	localparam int DIV_STAGES = 8;
	localparam int RS_QBITS = 32;
	localparam int YW_QBITS = 16;

	typedef logic signed [15:0] q14_t;
	typedef logic [14:0] mot_t;

	localparam q14_t Q14_POS = 16'sd16384;
	localparam q14_t Q14_NEG = -16'sd16384;
	localparam mot_t MOT_FULL = 15'd16384;

	localparam logic [7:0] REG_ROTOR0 = 8'd0;
	localparam logic [7:0] REG_ROTOR1 = 8'd1;
	localparam logic [7:0] REG_ROTOR2 = 8'd2;
	localparam logic [7:0] REG_ROTOR3 = 8'd3;

	localparam logic [47:0] COEF_RST [ROTORS] = '{
		48'd211109453758464,
		48'd211107306274816,
		48'd70368744194048,
		48'd70368744226816
	};

endpackage

### rtl/qmm_cmd_if.sv
interface qmm_cmd_if;
	logic valid;
	logic ready;
	logic signed [15:0] roll_cmd;
	logic signed [15:0] pitch_cmd;
	logic signed [15:0] yaw_cmd;
	logic signed [15:0] thrust_cmd;

	modport source (output valid, roll_cmd, pitch_cmd, yaw_cmd, thrust_cmd, input ready);
	modport sink (input valid, roll_cmd, pitch_cmd, yaw_cmd, thrust_cmd, output ready);
endinterface

### rtl/qmm_mot_if.sv
interface qmm_mot_if;
	logic valid;
	logic ready;
	logic [14:0] motor0;
	logic [14:0] motor1;
	logic [14:0] motor2;
	logic [14:0] motor3;

	modport source (output valid, motor0, motor1, motor2, motor3, input ready);
	modport sink (input valid, motor0, motor1, motor2, motor3, output ready);
endinterface

### rtl/qmm_cfg_if.sv
interface qmm_cfg_if;
	logic valid;
	logic ready;
	logic [7:0] index;
	logic [47:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/quad_motor_mixer.sv
// Quad-rotor motor mixer.
// The cmd channel carries one beat of roll, pitch, yaw and thrust commands in
// signed Q2.14; the mot channel returns one beat of four motor commands,
// unsigned 0 to 1.0 in Q1.14. The cfg channel writes the per-rotor roll, pitch
// and yaw coefficients (index 0 to 3); other indexes are ignored. cfg is always
// ready; the user must write it only with no beat in flight (not enforced).
// The datapath is a 16-stage pipeline: clamp, roll and pitch products, mix,
// minimum with the magnitude-times-thrust product, divider setup, eight divider
// stages (four quotient bits of the rescale and two of the yaw limit per stage,
// for all four rotors), yaw selection, yaw product and the output register.
// One beat can be accepted every cycle while the output is not stalled.
// When the output register holds a beat that mot does not take, the whole
// pipeline holds and cmd.ready drops in the same cycle; nothing is dropped or
// repeated. Reset empties the pipeline and loads the default coefficients of
// a plus-layout quad.
module quad_motor_mixer (
	input logic clk,
	input logic arst_n,
	qmm_cmd_if.sink cmd,
	qmm_cfg_if.sink cfg,
	qmm_mot_if.source mot
);
	import qmm_pkg::*;

	localparam int RS_PER = RS_QBITS / DIV_STAGES;
	localparam int YW_PER = YW_QBITS / DIV_STAGES;

	function automatic q14_t sat_pm(input q14_t x);
		if (x > Q14_POS) return Q14_POS;
		if (x < Q14_NEG) return Q14_NEG;
		return x;
	endfunction

	function automatic logic [14:0] sat_thr(input q14_t x);
		if (x[15]) return 15'd0;
		if (x > Q14_POS) return MOT_FULL;
		return x[14:0];
	endfunction

	function automatic mot_t clamp_mot(input logic signed [33:0] v);
		if (v < 34'sd0) return 15'd0;
		if (v >= 34'sd268435456) return MOT_FULL;
		return 15'(v[27:14]);
	endfunction

	// Restoring division: the upper half holds the partial remainder, the lower
	// half the dividend bits still to come and the quotient bits found so far.
	function automatic logic [63:0] rs_steps(input logic [63:0] acc, input logic [30:0] den);
		logic [63:0] a;
		logic [31:0] r;
		a = acc;
		for (int i = 0; i < RS_PER; i++) begin
			a = {a[62:0], 1'b0};
			r = a[63:32];
			if (r >= {1'b0, den}) begin
				a[63:32] = r - {1'b0, den};
				a[0] = 1'b1;
			end
		end
		return a;
	endfunction

	function automatic logic [31:0] yw_steps(input logic [31:0] acc, input logic [15:0] den);
		logic [31:0] a;
		logic [15:0] r;
		a = acc;
		for (int i = 0; i < YW_PER; i++) begin
			a = {a[30:0], 1'b0};
			r = a[31:16];
			if (r >= den) begin
				a[31:16] = r - den;
				a[0] = 1'b1;
			end
		end
		return a;
	endfunction

	logic [47:0] coef_q [ROTORS];
	q14_t rc_c [ROTORS];
	q14_t pc_c [ROTORS];
	q14_t ys_c [ROTORS];
	logic [15:0] ya_c [ROTORS];
	logic adv;

	logic v_s1;
	q14_t roll_s1, pitch_s1, yaw_s1;
	logic [14:0] thr_s1;

	logic v_s2;
	logic signed [31:0] prr_s2 [ROTORS];
	logic signed [31:0] ppr_s2 [ROTORS];
	q14_t yaw_s2;
	logic [14:0] thr_s2;

	logic v_s3;
	logic signed [31:0] mix_s3 [ROTORS];
	q14_t yaw_s3;
	logic [14:0] thr_s3;

	logic [28:0] t28_c;
	logic signed [31:0] o_c [ROTORS];
	logic [30:0] mabs_c [ROTORS];
	logic signed [31:0] omin_c;
	logic signed [33:0] dw_c;

	logic v_s4, neg_s4;
	logic [30:0] den_s4;
	logic [14:0] thr_s4;
	q14_t yaw_s4;
	logic signed [31:0] o_s4 [ROTORS];
	logic mneg_s4 [ROTORS];
	logic [59:0] mt_s4 [ROTORS];

	// Divider stages; index 0 is the setup stage.
	logic dv_v_sd [0:DIV_STAGES];
	logic dv_neg_sd [0:DIV_STAGES];
	logic [30:0] dv_den_sd [0:DIV_STAGES];
	logic [14:0] dv_thr_sd [0:DIV_STAGES];
	q14_t dv_yaw_sd [0:DIV_STAGES];
	logic signed [31:0] dv_o_sd [0:DIV_STAGES][ROTORS];
	logic dv_mneg_sd [0:DIV_STAGES][ROTORS];
	logic [63:0] dv_racc_sd [0:DIV_STAGES][ROTORS];
	logic [31:0] dv_yacc_sd [0:DIV_STAGES][ROTORS];
	logic dv_yovf_sd [0:DIV_STAGES][ROTORS];
	logic dv_ycand_sd [0:DIV_STAGES][ROTORS];

	logic signed [17:0] ysel_c;
	mot_t rsm_c [ROTORS];

	logic v_s14, neg_s14;
	q14_t yaw_s14;
	logic signed [31:0] o_s14 [ROTORS];
	mot_t rsm_s14 [ROTORS];

	logic signed [31:0] yp_c [ROTORS];
	logic v_s15, neg_s15;
	logic signed [32:0] sum_s15 [ROTORS];
	mot_t rsm_s15 [ROTORS];

	logic v_s16;
	mot_t mot_s16 [ROTORS];

	always_comb begin
		for (int r = 0; r < ROTORS; r++) begin
			rc_c[r] = q14_t'(coef_q[r][15:0]);
			pc_c[r] = q14_t'(coef_q[r][31:16]);
			ys_c[r] = q14_t'(coef_q[r][47:32]);
			ya_c[r] = ys_c[r][15] ? 16'(-ys_c[r]) : 16'(ys_c[r]);
		end
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROTORS; r++) coef_q[r] <= COEF_RST[r];
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ROTOR0: coef_q[0] <= cfg.data;
				REG_ROTOR1: coef_q[1] <= cfg.data;
				REG_ROTOR2: coef_q[2] <= cfg.data;
				REG_ROTOR3: coef_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	assign adv = !v_s16 || mot.ready;
	assign cmd.ready = adv;

	always_comb begin
		t28_c = {thr_s3, 14'b0};
		omin_c = 32'sd0;
		for (int r = 0; r < ROTORS; r++) begin
			o_c[r] = mix_s3[r] + $signed({3'b0, t28_c});
			mabs_c[r] = mix_s3[r][31] ? 31'(-mix_s3[r]) : 31'(mix_s3[r]);
			if (o_c[r] < omin_c) omin_c = o_c[r];
		end
		// With a negative output the divisor is thrust minus the lowest output.
		dw_c = $signed({5'b0, t28_c}) - 34'(omin_c);
	end

	// Yaw limit in rotor order: the candidate quotient replaces yaw when the
	// current yaw would drive a non-negative output below zero.
	always_comb begin
		logic [16:0] qm;
		logic signed [17:0] qs;
		logic signed [33:0] rv;
		logic [28:0] t28;
		t28 = {dv_thr_sd[DIV_STAGES], 14'b0};
		ysel_c = 18'(dv_yaw_sd[DIV_STAGES]);
		for (int r = 0; r < ROTORS; r++) begin
			qm = dv_yovf_sd[DIV_STAGES][r] ? 17'd32767 : {1'b0, dv_yacc_sd[DIV_STAGES][r][15:0]};
			qs = $signed({1'b0, qm});
			if (!ys_c[r][15]) qs = -qs;
			if (dv_ycand_sd[DIV_STAGES][r]) begin
				if (ys_c[r][15] ? (ysel_c > qs) : (ysel_c < qs)) ysel_c = qs;
			end
			rv = $signed({2'b0, dv_racc_sd[DIV_STAGES][r][31:0]});
			if (dv_mneg_sd[DIV_STAGES][r]) rv = -rv;
			rsm_c[r] = clamp_mot(rv + $signed({5'b0, t28}));
		end
	end

	always_comb begin
		for (int r = 0; r < ROTORS; r++) yp_c[r] = yaw_s14 * ys_c[r];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int k = 0; k <= DIV_STAGES; k++) dv_v_sd[k] <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
			v_s16 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			dv_v_sd[0] <= v_s4;
			for (int k = 1; k <= DIV_STAGES; k++) dv_v_sd[k] <= dv_v_sd[k-1];
			v_s14 <= dv_v_sd[DIV_STAGES];
			v_s15 <= v_s14;
			v_s16 <= v_s15;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			roll_s1 <= sat_pm(cmd.roll_cmd);
			pitch_s1 <= sat_pm(cmd.pitch_cmd);
			yaw_s1 <= sat_pm(cmd.yaw_cmd);
			thr_s1 <= sat_thr(cmd.thrust_cmd);

			for (int r = 0; r < ROTORS; r++) begin
				prr_s2[r] <= roll_s1 * rc_c[r];
				ppr_s2[r] <= pitch_s1 * pc_c[r];
			end
			yaw_s2 <= yaw_s1;
			thr_s2 <= thr_s1;

			for (int r = 0; r < ROTORS; r++) mix_s3[r] <= prr_s2[r] + ppr_s2[r];
			yaw_s3 <= yaw_s2;
			thr_s3 <= thr_s2;

			neg_s4 <= omin_c[31];
			den_s4 <= dw_c[30:0];
			thr_s4 <= thr_s3;
			yaw_s4 <= yaw_s3;
			for (int r = 0; r < ROTORS; r++) begin
				o_s4[r] <= o_c[r];
				mneg_s4[r] <= mix_s3[r][31];
				mt_s4[r] <= 60'(mabs_c[r]) * 60'(t28_c);
			end

			dv_neg_sd[0] <= neg_s4;
			dv_den_sd[0] <= den_s4;
			dv_thr_sd[0] <= thr_s4;
			dv_yaw_sd[0] <= yaw_s4;
			for (int r = 0; r < ROTORS; r++) begin
				dv_o_sd[0][r] <= o_s4[r];
				dv_mneg_sd[0][r] <= mneg_s4[r];
				dv_racc_sd[0][r] <= {4'b0, mt_s4[r]};
				dv_yacc_sd[0][r] <= o_s4[r];
				dv_yovf_sd[0][r] <= o_s4[r][31:16] >= ya_c[r];
				dv_ycand_sd[0][r] <= !o_s4[r][31] && (ys_c[r] != 16'sd0);
			end

			for (int k = 1; k <= DIV_STAGES; k++) begin
				dv_neg_sd[k] <= dv_neg_sd[k-1];
				dv_den_sd[k] <= dv_den_sd[k-1];
				dv_thr_sd[k] <= dv_thr_sd[k-1];
				dv_yaw_sd[k] <= dv_yaw_sd[k-1];
				for (int r = 0; r < ROTORS; r++) begin
					dv_o_sd[k][r] <= dv_o_sd[k-1][r];
					dv_mneg_sd[k][r] <= dv_mneg_sd[k-1][r];
					dv_racc_sd[k][r] <= rs_steps(dv_racc_sd[k-1][r], dv_den_sd[k-1]);
					dv_yacc_sd[k][r] <= yw_steps(dv_yacc_sd[k-1][r], ya_c[r]);
					dv_yovf_sd[k][r] <= dv_yovf_sd[k-1][r];
					dv_ycand_sd[k][r] <= dv_ycand_sd[k-1][r];
				end
			end

			neg_s14 <= dv_neg_sd[DIV_STAGES];
			yaw_s14 <= 16'(ysel_c);
			for (int r = 0; r < ROTORS; r++) begin
				o_s14[r] <= dv_o_sd[DIV_STAGES][r];
				rsm_s14[r] <= rsm_c[r];
			end

			neg_s15 <= neg_s14;
			for (int r = 0; r < ROTORS; r++) begin
				sum_s15[r] <= 33'(o_s14[r]) + 33'(yp_c[r]);
				rsm_s15[r] <= rsm_s14[r];
			end

			for (int r = 0; r < ROTORS; r++)
				mot_s16[r] <= neg_s15 ? rsm_s15[r] : clamp_mot(34'(sum_s15[r]));
		end
	end

	assign mot.valid = v_s16;
	assign mot.motor0 = mot_s16[0];
	assign mot.motor1 = mot_s16[1];
	assign mot.motor2 = mot_s16[2];
	assign mot.motor3 = mot_s16[3];

	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		mot.valid && !mot.ready |-> !cmd.ready)
		else $error("input accepted while the output register is stalled");

	a_beat_enters: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> v_s1)
		else $error("accepted beat did not enter the first stage");

	a_yaw_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v_sd[DIV_STAGES] |-> (ysel_c <= 18'sd16384) && (ysel_c >= -18'sd16384))
		else $error("limited yaw left the unit range");

	a_rescale_rem: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v_sd[DIV_STAGES] && dv_neg_sd[DIV_STAGES]
		|-> dv_racc_sd[DIV_STAGES][0][63:32] < {1'b0, dv_den_sd[DIV_STAGES]})
		else $error("rescale remainder not below divisor");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		mot.valid |-> (mot.motor0 <= MOT_FULL) && (mot.motor1 <= MOT_FULL)
			&& (mot.motor2 <= MOT_FULL) && (mot.motor3 <= MOT_FULL))
		else $error("motor command above full scale");

endmodule
